>>> rtl/core/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared widths, constants and codes for the MSE loss and gradient core.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Field widths
  localparam int PRED_W  = 16;  // prediction, signed Q4.12
  localparam int LABEL_W = 8;   // label index
  localparam int GRAD_W  = 18;  // gradient, signed Q6.12
  localparam int LOSS_W  = 32;  // mean loss, Q8.24
  localparam int NCLS_W  = 9;   // num_classes register

  // Datapath widths
  localparam int ERR_W  = 17;   // error p or p - 1.0, signed Q.12
  localparam int MAG_W  = 16;   // error magnitude, at most 36864
  localparam int PROD_W = 32;   // squared error, Q8.24
  localparam int SUM_W  = 48;   // batch accumulator
  localparam int ALU_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(SUM_W);

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_BIT = 2;  // paddr bit that selects the register

  // Parameter defaults
  localparam int DEF_MAX_CLASSES        = 256;
  localparam int DEF_MAX_BATCH_ELEMENTS = 65536;

  // Constants
  localparam logic [NCLS_W-1:0] NUM_CLASSES_RESET = 9'd10;
  localparam logic [ERR_W-1:0]  ONE_Q12           = 17'd4096;
  localparam logic [SUM_W-1:0]  SUM_MAX           = '1;

  // Register indexes
  localparam logic REG_NUM_CLASSES = 1'b0;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } seq_state_t;

endpackage

>>> rtl/core/mse_if.sv
// ----------------------------------------------------------------------------
// mse_in_if / mse_out_if
// Valid/ready channels that carry input and result items of the MSE core.
// ----------------------------------------------------------------------------
interface mse_in_if import mse_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PRED_W-1:0]  prediction;
  logic        [LABEL_W-1:0] label;
  logic                      last_of_batch;

  modport source (output valid, prediction, label, last_of_batch, input ready);
  modport sink   (input valid, prediction, label, last_of_batch, output ready);
endinterface

interface mse_out_if import mse_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] gradient;
  logic        [LOSS_W-1:0] mean_loss;
  logic                     loss_valid;

  modport source (output valid, gradient, mean_loss, loss_valid, input ready);
  modport sink   (input valid, gradient, mean_loss, loss_valid, output ready);
endinterface

>>> rtl/core/mse_loss_and_gradient_core.sv
// ----------------------------------------------------------------------------
// mse_loss_and_gradient_core
// MSE loss and gradient against a one-hot target, one class score per item.
// ----------------------------------------------------------------------------
// Input items (din) carry a Q4.12 class score, the sample's label and a
// last-of-batch flag. Each accepted item gives exactly one result item
// (dout): the gradient 2*(p-1) at the label column and 2*p elsewhere, plus,
// on the last item of a batch, the batch mean squared error in Q8.24 with
// loss_valid set. The row width comes from the num_classes register on the
// APB port; write it only while the core is idle.
// One 49-bit adder is shared by the square, accumulate and batch-mean steps:
// the square is a shift-add loop, the accumulate a single add, and the batch
// mean a restoring divide. An ordinary item passes S_MUL, S_ACC and S_OUT
// before its result is loaded into the output register; the last item of a
// batch also passes S_DIV after S_ACC. din.ready is low while an item is
// in work. The result sits in an output register, so a stalled receiver
// does not stop the next item from being accepted and worked on; only its
// hand-off waits. Reset clears the counters, the accumulator and the
// output valid, and sets num_classes to 10.
// ----------------------------------------------------------------------------
module mse_loss_and_gradient_core import mse_pkg::*; #(
  parameter int MAX_CLASSES        = DEF_MAX_CLASSES,
  parameter int MAX_BATCH_ELEMENTS = DEF_MAX_BATCH_ELEMENTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  mse_in_if.sink                din,
  mse_out_if.source             dout
);

  localparam int ROW_W = $clog2(MAX_CLASSES + 1);
  localparam int COL_W = $clog2(MAX_CLASSES);
  localparam int CNT_W = $clog2(MAX_BATCH_ELEMENTS + 1);

  seq_state_t          state;
  logic [ROW_W-1:0]    row_width;
  logic [COL_W-1:0]    column_index;
  logic [SUM_W-1:0]    error_sum;
  logic [CNT_W-1:0]    element_count;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    rem;
  logic [PROD_W-1:0]   prod;
  logic [MAG_W-1:0]    mag;
  logic [GRAD_W-1:0]   grad_q;
  logic                last_q;
  logic                out_valid;
  logic [GRAD_W-1:0]   out_gradient;
  logic [LOSS_W-1:0]   out_mean_loss;
  logic                out_loss_valid;

  logic                label_hit;
  logic [ERR_W-1:0]    err_ext;
  logic [ERR_W-1:0]    err;
  logic [ERR_W-1:0]    err_neg;
  logic [MAG_W-1:0]    mag_in;
  logic [ROW_W-1:0]    col_inc;
  logic [COL_W-1:0]    col_next;
  logic [CNT_W-1:0]    count_inc;
  logic [LOSS_W-1:0]   mean_sat;
  logic                div_ok;
  logic                out_load;
  alu_op_t             alu_op;
  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic [ALU_W-1:0]    alu_y;

  mse_cfg #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .row_width (row_width)
  );

  assign pready = 1'b1;

  mse_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Error against the one-hot target
  assign label_hit = (int'(column_index) == int'(din.label));
  assign err_ext   = {din.prediction[PRED_W-1], din.prediction};
  assign err       = label_hit ? (err_ext - ONE_Q12) : err_ext;
  assign err_neg   = ERR_W'(0) - err;
  assign mag_in    = err[ERR_W-1] ? err_neg[MAG_W-1:0] : err[MAG_W-1:0];

  // Column counter wraps at the row width
  assign col_inc  = ROW_W'(column_index) + ROW_W'(1);
  assign col_next = (col_inc >= row_width) ? '0 : col_inc[COL_W-1:0];

  // Element count saturates at the batch limit
  assign count_inc = (element_count == CNT_W'(MAX_BATCH_ELEMENTS)) ?
                     element_count : element_count + CNT_W'(1);

  // Quotient ends up in error_sum; clamp to the output width
  assign mean_sat = (|error_sum[SUM_W-1:LOSS_W]) ? '1 : error_sum[LOSS_W-1:0];

  assign div_ok   = ~alu_y[ALU_W-1];
  assign out_load = (state == S_OUT) && (!out_valid || dout.ready);

  // Steer the shared adder
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      S_MUL: begin
        alu_a = ALU_W'(prod[PROD_W-1:MAG_W]);
        alu_b = prod[0] ? ALU_W'(mag) : '0;
      end
      S_ACC: begin
        alu_a = ALU_W'(error_sum);
        alu_b = ALU_W'(prod);
      end
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'({rem, error_sum[SUM_W-1]});
        alu_b  = ALU_W'(element_count);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // Sequencer and batch state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      column_index  <= '0;
      error_sum     <= '0;
      element_count <= '0;
      step          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (din.valid) begin
            column_index  <= din.last_of_batch ? '0 : col_next;
            element_count <= count_inc;
            step          <= STEP_W'(MAG_W - 1);
            state         <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          error_sum <= alu_y[SUM_W] ? SUM_MAX : alu_y[SUM_W-1:0];
          if (last_q) begin
            step  <= STEP_W'(SUM_W - 1);
            state <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          error_sum <= {error_sum[SUM_W-2:0], div_ok};
          step      <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            if (last_q) begin
              error_sum     <= '0;
              element_count <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && din.valid) begin
      mag    <= mag_in;
      prod   <= PROD_W'(mag_in);
      grad_q <= {err, 1'b0};
      last_q <= din.last_of_batch;
    end
    if (state == S_MUL) begin
      prod <= {alu_y[MAG_W:0], prod[MAG_W-1:1]};
    end
    if (state == S_ACC) begin
      rem <= '0;
    end
    if (state == S_DIV) begin
      rem <= div_ok ? alu_y[CNT_W-1:0] : {rem[CNT_W-2:0], error_sum[SUM_W-1]};
    end
    if (out_load) begin
      out_gradient   <= grad_q;
      out_loss_valid <= last_q;
      out_mean_loss  <= last_q ? mean_sat : '0;
    end
  end

  assign din.ready       = (state == S_IDLE);
  assign dout.valid      = out_valid;
  assign dout.gradient   = out_gradient;
  assign dout.mean_loss  = out_mean_loss;
  assign dout.loss_valid = out_loss_valid;

  // One item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> !din.ready)
    else $error("item accepted while another was in work");

  // The divider never sees an empty batch
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> element_count != '0)
    else $error("divide with zero element count");

  // Column stays inside the largest row
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    int'(column_index) < MAX_CLASSES)
    else $error("column index out of range");

endmodule

>>> rtl/core/mse_cfg.sv
// ----------------------------------------------------------------------------
// mse_cfg
// APB register block: holds num_classes and derives the effective row width.
// ----------------------------------------------------------------------------
module mse_cfg import mse_pkg::*; #(
  parameter  int MAX_CLASSES = DEF_MAX_CLASSES,
  localparam int ROW_W       = $clog2(MAX_CLASSES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic [ROW_W-1:0]      row_width
);

  logic [NCLS_W-1:0] num_classes;
  logic              wr_en;
  logic              sel_ncls;

  assign wr_en    = psel & penable & pwrite;
  assign sel_ncls = (paddr[REG_IDX_BIT] == REG_NUM_CLASSES);

  // Write the register in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= NUM_CLASSES_RESET;
    end else if (wr_en && sel_ncls) begin
      num_classes <= pwdata[NCLS_W-1:0];
    end
  end

  // Read back
  assign prdata = sel_ncls ? APB_DATA_W'(num_classes) : '0;

  // Zero or oversized widths act as the largest row
  always_comb begin
    if (num_classes == '0 || int'(num_classes) > MAX_CLASSES) begin
      row_width = ROW_W'(MAX_CLASSES);
    end else begin
      row_width = ROW_W'(num_classes);
    end
  end

endmodule

>>> rtl/core/mse_alu.sv
// ----------------------------------------------------------------------------
// mse_alu
// Shared adder/subtractor for the multiply, accumulate and divide steps.
// ----------------------------------------------------------------------------
module mse_alu import mse_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] y
);

  logic [ALU_W-1:0] b_eff;

  // Invert b and carry in one to subtract
  assign b_eff = (op == ALU_SUB) ? ~b : b;
  assign y     = a + b_eff + ALU_W'(op == ALU_SUB);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MSE loss and gradient core.
// ----------------------------------------------------------------------------
// A queue of class scores feeds a clocked driver on din. Every accepted
// score is run through a local model of the core: column counter, one-hot
// error, squared-error accumulator and the batch mean. The model's output is
// queued and compared, field by field, with each result taken from dout.
// The row width is rewritten between phases, with zero and over-range
// values among them. Both channels idle at random, and the receiver holds
// off once for a long stretch so that the core backs up and stalls din.
// ----------------------------------------------------------------------------
module tb_top import mse_pkg::*; ();

  localparam int MAX_CLS   = DEF_MAX_CLASSES;
  localparam int MAX_ELEMS = DEF_MAX_BATCH_ELEMENTS;

  typedef struct {
    logic signed [PRED_W-1:0]  prediction;
    logic        [LABEL_W-1:0] label;
    logic                      last_of_batch;
  } score_t;

  typedef struct {
    logic signed [GRAD_W-1:0] gradient;
    logic        [LOSS_W-1:0] mean_loss;
    logic                     loss_valid;
  } grad_loss_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mse_in_if  din_if ();
  mse_out_if dout_if ();

  mse_loss_and_gradient_core #(
    .MAX_CLASSES       (MAX_CLS),
    .MAX_BATCH_ELEMENTS(MAX_ELEMS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .din    (din_if),
    .dout   (dout_if)
  );

  // Stimulus and scoreboard state
  score_t     score_q[$];
  grad_loss_t grad_loss_q[$];
  int         scores_queued = 0;
  int         results_seen  = 0;
  int         mismatches    = 0;
  bit         in_quiet      = 0;
  bit         out_quiet     = 0;
  bit         hold_arm      = 0;
  bit         hold_done     = 0;
  bit         in_taken      = 0;
  int         send_gap      = 0;
  int         stall_left    = 0;
  int         hold_left     = 0;

  // Model copy of the core's register and state
  logic [NCLS_W-1:0] class_count;
  logic [7:0]        column;
  logic [SUM_W-1:0]  sq_err_sum;
  logic [16:0]       elem_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Pick an idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a class score: full range, around 1.0, the extremes, or small
  function automatic logic signed [PRED_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return PRED_W'($urandom);
    if (r < 70) return PRED_W'(4096 + $signed($urandom_range(0, 128)) - 64);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0:       return -16'sd32768;
        1:       return 16'sd32767;
        2:       return 16'sd0;
        default: return 16'sd4096;
      endcase
    end
    return PRED_W'($signed($urandom_range(0, 1024)) - 512);
  endfunction

  // Work out the gradient and, on the last item, the batch mean
  task automatic predict_grad_loss(input logic signed [PRED_W-1:0] p,
                                   input logic [LABEL_W-1:0] lbl, input logic last);
    int               width;
    longint           err;
    logic [SUM_W:0]   total;
    logic [SUM_W-1:0] quot;
    grad_loss_t       r;
    width = (class_count == 0 || class_count > MAX_CLS) ? MAX_CLS : int'(class_count);
    err = p;
    if (column == lbl) err = err - longint'(ONE_Q12);
    r.gradient   = GRAD_W'(2 * err);
    r.mean_loss  = '0;
    r.loss_valid = 1'b0;
    total = {1'b0, sq_err_sum} + (SUM_W + 1)'(err * err);
    sq_err_sum = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    if (elem_count < MAX_ELEMS) elem_count = elem_count + 1'b1;
    if (int'(column) + 1 >= width) column = '0;
    else column = column + 1'b1;
    if (last) begin
      quot = sq_err_sum / elem_count;
      r.mean_loss  = (quot > 48'hFFFF_FFFF) ? '1 : quot[LOSS_W-1:0];
      r.loss_valid = 1'b1;
      sq_err_sum = '0;
      elem_count = '0;
      column     = '0;
    end
    grad_loss_q.push_back(r);
  endtask

  // Track register writes and predict every accepted item
  always @(posedge clk) begin
    if (rst) begin
      class_count <= NUM_CLASSES_RESET;
      column      = '0;
      sq_err_sum  = '0;
      elem_count  = '0;
      in_taken    <= 1'b0;
    end else begin
      in_taken <= din_if.valid && din_if.ready;
      if (psel && penable && pwrite && pready &&
          paddr == (APB_ADDR_W'(REG_NUM_CLASSES) << REG_IDX_BIT))
        class_count <= pwdata[NCLS_W-1:0];
      if (din_if.valid && din_if.ready)
        predict_grad_loss(din_if.prediction, din_if.label, din_if.last_of_batch);
    end
  end

  // Offer the next queued score, with a random gap after each hand-off
  always @(negedge clk) begin
    score_t s;
    if (rst) begin
      din_if.valid         <= 1'b0;
      din_if.prediction    <= '0;
      din_if.label         <= '0;
      din_if.last_of_batch <= 1'b0;
      send_gap             <= 0;
    end else if (!din_if.valid || in_taken) begin
      if (send_gap > 0) begin
        din_if.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (score_q.size() != 0) begin
        s = score_q.pop_front();
        din_if.valid         <= 1'b1;
        din_if.prediction    <= s.prediction;
        din_if.label         <= s.label;
        din_if.last_of_batch <= s.last_of_batch;
        send_gap             <= pick_gap(in_quiet);
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  // Drive ready: random stalls, plus one long hold-off when armed
  always @(negedge clk) begin
    int gap;
    if (rst) begin
      dout_if.ready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
    end else if (hold_left > 0) begin
      dout_if.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      dout_if.ready <= 1'b0;
      hold_left     <= 300;
      hold_done     <= 1'b1;
    end else if (stall_left > 0) begin
      dout_if.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      gap = pick_gap(out_quiet);
      dout_if.ready <= (gap == 0);
      stall_left    <= (gap > 0) ? gap - 1 : 0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    grad_loss_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      results_seen++;
      if (grad_loss_q.size() == 0) begin
        $error("result with no item pending: gradient %0d", dout_if.gradient);
        mismatches++;
      end else begin
        want = grad_loss_q.pop_front();
        if (dout_if.gradient !== want.gradient) begin
          $error("gradient: expected %0d, got %0d", want.gradient, dout_if.gradient);
          mismatches++;
        end
        if (dout_if.mean_loss !== want.mean_loss) begin
          $error("mean_loss: expected %0h, got %0h", want.mean_loss, dout_if.mean_loss);
          mismatches++;
        end
        if (dout_if.loss_valid !== want.loss_valid) begin
          $error("loss_valid: expected %0b, got %0b", want.loss_valid, dout_if.loss_valid);
          mismatches++;
        end
      end
    end
  end

  task automatic push_score(input logic signed [PRED_W-1:0] p,
                            input logic [LABEL_W-1:0] lbl, input logic last);
    score_t s;
    s.prediction    = p;
    s.label         = lbl;
    s.last_of_batch = last;
    score_q.push_back(s);
    scores_queued++;
  endtask

  // Write num_classes, then read it back
  task automatic write_classes(input logic [NCLS_W-1:0] value);
    logic [APB_ADDR_W-1:0] addr;
    addr = APB_ADDR_W'(REG_NUM_CLASSES) << REG_IDX_BIT;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[NCLS_W-1:0] !== value) begin
      $error("num_classes: expected %0d, got %0d", value, prdata[NCLS_W-1:0]);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Start a phase: new row width, new idling mood; leaves time at a rising edge
  task automatic open_phase(input logic [NCLS_W-1:0] value);
    write_classes(value);
    @(posedge clk);
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_drained();
    while (results_seen < scores_queued) @(negedge clk);
  endtask

  // Random phase: mostly whole batches of rows, whole rows at widths up to 32; some noise
  task automatic random_phase(input logic [NCLS_W-1:0] value, input int target,
                              input bit full_row, input bit long_hold);
    int                 width;
    int                 n;
    int                 rows;
    int                 len;
    logic [LABEL_W-1:0] lbl;
    width = (value == 0 || value > MAX_CLS) ? MAX_CLS : int'(value);
    open_phase(value);
    n = 0;
    if (full_row) begin
      lbl = LABEL_W'($urandom_range(0, width - 1));
      for (int i = 0; i < width; i++) push_score(pick_score(), lbl, i == width - 1);
      n = width;
    end
    while (n < target) begin
      if ($urandom_range(0, 4) != 0) begin
        rows = (width > 32) ? 1 : $urandom_range(1, 4);
        for (int r = 0; r < rows; r++) begin
          lbl = ($urandom_range(0, 9) == 0) ? LABEL_W'($urandom_range(0, 255))
                                            : LABEL_W'($urandom_range(0, width - 1));
          len = (width > 32) ? $urandom_range(1, 48) : width;
          for (int i = 0; i < len; i++)
            push_score(pick_score(), lbl, r == rows - 1 && i == len - 1);
          n += len;
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          push_score(pick_score(), LABEL_W'($urandom_range(0, 255)),
                     $urandom_range(0, 7) == 0);
        n += len;
      end
    end
    if (long_hold) hold_arm = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset width of ten: extremes of the score around and at the label
    @(posedge clk);
    push_score(16'sd32767, 8'd3, 1'b0);
    push_score(-16'sd32768, 8'd3, 1'b0);
    push_score(16'sd0, 8'd3, 1'b0);
    push_score(16'sd4096, 8'd3, 1'b0);
    push_score(16'sd1, 8'd3, 1'b0);
    push_score(-16'sd1, 8'd3, 1'b0);
    push_score(16'sd4095, 8'd3, 1'b0);
    push_score(16'sd4097, 8'd3, 1'b0);
    push_score(16'sd16384, 8'd3, 1'b0);
    push_score(-16'sd4096, 8'd3, 1'b0);
    push_score(-16'sd32768, 8'd0, 1'b0);
    push_score(16'sd32767, 8'd0, 1'b1);
    wait_drained();

    // One class per row; a label past the row never matches
    open_phase(9'd1);
    push_score(16'sd0, 8'd0, 1'b0);
    push_score(16'sd32767, 8'd0, 1'b0);
    push_score(-16'sd32768, 8'd1, 1'b1);
    wait_drained();

    // Zero acts as the widest row; leave the batch open mid-row
    open_phase(9'd0);
    push_score(16'sd100, 8'd1, 1'b0);
    push_score(16'sd4096, 8'd1, 1'b0);
    wait_drained();

    // Shrink the row under the counter so it wraps on the next item
    open_phase(9'd2);
    push_score(16'sd4096, 8'd2, 1'b0);
    push_score(-16'sd5, 8'd0, 1'b1);
    wait_drained();

    // All-ones width acts as the widest row
    open_phase(9'd511);
    push_score(-16'sd1, 8'd255, 1'b1);
    wait_drained();

    random_phase(9'd3, 50, 1'b0, 1'b1);
    random_phase(9'd1, 40, 1'b0, 1'b0);
    random_phase(9'd10, 50, 1'b0, 1'b0);
    random_phase(9'd256, 60, 1'b1, 1'b0);
    random_phase(9'd7, 40, 1'b0, 1'b0);
    random_phase(9'd0, 40, 1'b0, 1'b0);
    random_phase(9'd2, 30, 1'b0, 1'b0);
    random_phase(9'd300, 30, 1'b0, 1'b0);
    random_phase(NCLS_W'($urandom_range(1, 16)), 40, 1'b0, 1'b0);
    random_phase(NCLS_W'($urandom_range(17, 255)), 30, 1'b0, 1'b0);

    // Let a stray late result show up before the verdict
    repeat (80) @(negedge clk);
    if (grad_loss_q.size() != 0) begin
      $error("%0d predicted results never arrived", grad_loss_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mse_pkg.sv
rtl/core/mse_if.sv
rtl/core/mse_cfg.sv
rtl/core/mse_alu.sv
rtl/core/mse_loss_and_gradient_core.sv
tb/tb_top.sv
